/* design/dmm_pkg.sv */
// Shared types and constants for the dense matrix multiply unit.
// Depends on nothing; every other file of the block but dmm_ram imports it.
package dmm_pkg;

    // Kind of an input word, carried in tuser.
    typedef enum logic [1:0] {
        ACT_WRITE_A = 2'd0,
        ACT_WRITE_B = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_LEN = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    localparam int CFG_W       = 4;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    // Port field widths.
    localparam int POS_W   = 3;
    localparam int VALUE_W = 16;
    localparam int RES_W   = 40;
    // Sum of up to eight saturated products needs three guard bits.
    localparam int ACC_W   = RES_W + 3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic signed [63:0] RES_MAX = 64'sd549755813887;
    localparam logic signed [63:0] RES_MIN = -64'sd549755813888;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_a;   // store the input element into A
        logic wr_b;   // store the input element into B
        logic issue;  // read one A and one B element for the running sum
        logic first;  // this read starts a new sum
        logic load;   // move the finished sum into the output register
        logic last;   // the loaded result ends the run
    } dmm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wr_in_range; // write position lies inside the stores
        logic out_free;    // output register can take a result this cycle
    } dmm_status_t;

endpackage

/* design/dmm_ram.sv */
// Generic one-write, one-read RAM with a registered read port.
// Depends on nothing.
module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/dmm_ctrl.sv */
// Controller of the dense matrix multiply unit: configuration registers,
// loop counters and the run state machine. Depends on dmm_pkg.
module dmm_ctrl import dmm_pkg::*; #(
    parameter int MAX_DIM = 8,
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // Input handshake and word kind
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             in_action,
    // Datapath interface
    output dmm_cmd_t               cmd,
    input  dmm_status_t            status,
    output logic [IDX_W-1:0]       row_i,
    output logic [IDX_W-1:0]       col_j,
    output logic [IDX_W-1:0]       sum_k
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FLUSH,
        ST_LOAD
    } state_t;

    state_t           state_reg;
    logic [CFG_W-1:0] rows_a_reg;
    logic [CFG_W-1:0] inner_len_reg;
    logic [CFG_W-1:0] cols_b_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic             flush_reg;

    logic [CNT_W-1:0] m_eff;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] p_eff;
    logic             accept;
    logic             k_done;
    logic             j_done;
    logic             i_done;

    // A dimension of zero acts as one, one above the store size as the size.
    function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
        logic [CNT_W-1:0] r;
        if (d == '0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = CNT_W'(MAX_DIM);
        end
        else
        begin
            r = CNT_W'(d);
        end
        return r;
    endfunction

    assign m_eff = eff_dim(rows_a_reg);
    assign n_eff = eff_dim(inner_len_reg);
    assign p_eff = eff_dim(cols_b_reg);

    assign k_done = (CNT_W'(k_reg) + 1'b1) == n_eff;
    assign j_done = (CNT_W'(j_reg) + 1'b1) == p_eff;
    assign i_done = (CNT_W'(i_reg) + 1'b1) == m_eff;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Commands decoded from the state and the counters.
    always_comb
    begin
        cmd       = '0;
        cmd.wr_a  = accept && (in_action == ACT_WRITE_A) && status.wr_in_range;
        cmd.wr_b  = accept && (in_action == ACT_WRITE_B) && status.wr_in_range;
        cmd.issue = (state_reg == ST_ISSUE);
        cmd.first = (state_reg == ST_ISSUE) && (k_reg == '0);
        cmd.load  = (state_reg == ST_LOAD) && status.out_free;
        cmd.last  = i_done && j_done;
    end

    assign row_i = i_reg;
    assign col_j = j_reg;
    assign sum_k = k_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_len_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_LEN: inner_len_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Run state machine and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (in_action == ACT_COMPUTE))
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (k_done)
                    begin
                        k_reg     <= '0;
                        flush_reg <= 1'b0;
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_FLUSH:
                begin
                    // The flush covers the RAM read and the product register.
                    if (flush_reg)
                    begin
                        state_reg <= ST_LOAD;
                    end
                    flush_reg <= 1'b1;
                end
                ST_LOAD:
                begin
                    if (status.out_free)
                    begin
                        if (i_done && j_done)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            if (j_done)
                            begin
                                j_reg <= '0;
                                i_reg <= i_reg + 1'b1;
                            end
                            else
                            begin
                                j_reg <= j_reg + 1'b1;
                            end
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/dmm_datapath.sv */
// Datapath of the dense matrix multiply unit: element stores, multiplier,
// accumulator and output register. Depends on dmm_pkg and dmm_ram.
module dmm_datapath import dmm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16,
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Element write fields from the input word
    input  logic [POS_W-1:0]     in_row,
    input  logic [POS_W-1:0]     in_col,
    input  logic [VALUE_W-1:0]   in_value,
    // Controller interface
    input  dmm_cmd_t             cmd,
    output dmm_status_t          status,
    input  logic [IDX_W-1:0]     row_i,
    input  logic [IDX_W-1:0]     col_j,
    input  logic [IDX_W-1:0]     sum_k,
    // Result word
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_W-1:0]     out_row,
    output logic [POS_W-1:0]     out_col,
    output logic signed [RES_W-1:0] out_value,
    output logic                 out_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic [ELEM_WIDTH-1:0]    wr_elem;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        a_raddr;
    logic [ADDR_W-1:0]        b_raddr;
    logic [ELEM_WIDTH-1:0]    a_rdata;
    logic [ELEM_WIDTH-1:0]    b_rdata;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [63:0]       prod_ext;
    logic signed [RES_W-1:0]  prod_sat;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [RES_W-1:0]  acc_sat;

    logic                     s1_valid_reg;
    logic                     s1_first_reg;
    logic                     s2_valid_reg;
    logic                     s2_first_reg;
    logic signed [RES_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic [POS_W-1:0]         out_row_reg;
    logic [POS_W-1:0]         out_col_reg;
    logic signed [RES_W-1:0]  out_value_reg;
    logic                     out_last_reg;

    // The element is the low ELEM_WIDTH bits of the value field.
    generate
        if (ELEM_WIDTH <= VALUE_W)
        begin : g_elem_narrow
            assign wr_elem = in_value[ELEM_WIDTH-1:0];
        end
        else
        begin : g_elem_wide
            assign wr_elem = ELEM_WIDTH'(in_value);
        end
    endgenerate

    // Store addresses are row * MAX_DIM + column.
    assign wr_addr = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
    assign a_raddr = ADDR_W'(int'(row_i) * MAX_DIM + int'(sum_k));
    assign b_raddr = ADDR_W'(int'(sum_k) * MAX_DIM + int'(col_j));

    assign status.wr_in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign status.out_free    = !out_valid_reg || out_ready;

    dmm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (cmd.wr_a),
        .waddr (wr_addr),
        .wdata (wr_elem),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dmm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (cmd.wr_b),
        .waddr (wr_addr),
        .wdata (wr_elem),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Product of the two read elements, saturated to the result range.
    always_comb
    begin
        prod_full = $signed(a_rdata) * $signed(b_rdata);
        prod_ext  = 64'(prod_full);
        if (prod_ext > RES_MAX)
        begin
            prod_sat = RES_W'(RES_MAX);
        end
        else if (prod_ext < RES_MIN)
        begin
            prod_sat = RES_W'(RES_MIN);
        end
        else
        begin
            prod_sat = RES_W'(prod_ext);
        end
    end

    // Running sum and its saturation to the result range.
    always_comb
    begin
        if (s2_first_reg)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        if (acc_reg > ACC_W'(RES_MAX))
        begin
            acc_sat = RES_W'(RES_MAX);
        end
        else if (acc_reg < ACC_W'(RES_MIN))
        begin
            acc_sat = RES_W'(RES_MIN);
        end
        else
        begin
            acc_sat = RES_W'(acc_reg);
        end
    end

    // Pipeline tags that follow the RAM read and the product register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s1_first_reg <= cmd.first;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: product, sum and the result word.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_sat;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load)
        begin
            out_row_reg   <= POS_W'(row_i);
            out_col_reg   <= POS_W'(col_j);
            out_value_reg <= acc_sat;
            out_last_reg  <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

/* design/dense_matrix_multiply_unit.sv */
// Top level of the dense matrix multiply unit, C = A x B.
// Depends on dmm_pkg, dmm_ctrl, dmm_datapath and dmm_ram.
//
// Usage:
//   Input words on s_axis carry an action in tuser. A write action stores
//   one element of A or B at its row and column; a write outside the stores
//   is dropped. A compute action emits rows_a * cols_b results on m_axis in
//   row-major order, the final one marked with tlast.
//   Set rows_a, inner_len and cols_b through the cfg port while idle.
// Flow:
//   Write words are taken one per cycle while idle. After a compute word
//   the block stops taking input until its last result is in the output
//   register. Each result is built from inner_len reads through the one
//   read port of each store, then passes the RAM read and the product
//   register and is loaded into the output register.
// Reset:
//   rst_n clears the controller and the output valid; the dimensions return
//   to 8. Store contents are undefined until written.
// Backpressure:
//   A stalled receiver holds the result in the output register; the next
//   sum finishes and then waits. No input word is taken until the last
//   result of the run has been loaded into the output register.
module dense_matrix_multiply_unit import dmm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // Input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // row_index[2:0], col_index[5:3],
                                                  // elem_value[21:6], zero[23:22]
    input  logic [1:0]             s_axis_tuser,  // action[1:0]
    // Result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // out_row[2:0], out_col[5:3],
                                                  // product_value[45:6], zero[47:46]
    output logic                   m_axis_tlast   // last
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    dmm_cmd_t                cmd;
    dmm_status_t             status;
    logic [IDX_W-1:0]        row_i;
    logic [IDX_W-1:0]        col_j;
    logic [IDX_W-1:0]        sum_k;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [RES_W-1:0] out_value;

    dmm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .cmd       (cmd),
        .status    (status),
        .row_i     (row_i),
        .col_j     (col_j),
        .sum_k     (sum_k)
    );

    dmm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_row    (s_axis_tdata[2:0]),
        .in_col    (s_axis_tdata[5:3]),
        .in_value  (s_axis_tdata[21:6]),
        .cmd       (cmd),
        .status    (status),
        .row_i     (row_i),
        .col_j     (col_j),
        .sum_k     (sum_k),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_axis_tlast)
    );

    // Pack the result word, lowest field first.
    assign m_axis_tdata = {2'b00, out_value, out_col, out_row};

endmodule

/* sim/dmm_result_checker.sv */
// Result checker for the dense matrix multiply unit: watches the config port and both
// stream channels, predicts every product word and compares it field by field.
// Depends on dmm_pkg for field widths, register indexes and action codes.
module dmm_result_checker import dmm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // row_index[2:0], col_index[5:3],
                                                  // elem_value[21:6], zero[23:22]
    input  logic [1:0]             s_axis_tuser,  // action[1:0]
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_DATA_W-1:0]  m_axis_tdata,  // out_row[2:0], out_col[5:3],
                                                  // product_value[45:6], zero[47:46]
    input  logic                   m_axis_tlast,  // last
    output int                     mismatch_count,
    output int                     results_outstanding
);

    typedef struct packed {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [RES_W-1:0] value;
        logic                    last;
    } product_t;

    // Shadow copies of the operand stores and the dimension registers.
    logic signed [VALUE_W-1:0] a_elem [MAX_DIM*MAX_DIM];
    logic signed [VALUE_W-1:0] b_elem [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0] rows_a;
    logic [CFG_W-1:0] inner_len;
    logic [CFG_W-1:0] cols_b;

    product_t expected_products[$];
    int errors = 0;
    int pending = 0;

    assign mismatch_count      = errors;
    assign results_outstanding = pending;

    // A zero dimension behaves as one, anything above the store size as the store size.
    function automatic int effective_dim(logic [CFG_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // Saturate to the 40-bit result range; only reachable with much wider elements.
    function automatic longint clamp_result(longint v);
        if (v > RES_MAX)
            return RES_MAX;
        if (v < RES_MIN)
            return RES_MIN;
        return v;
    endfunction

    // Exact Q10.30 dot product of row i of A with column j of B.
    function automatic longint dot_product(int i, int j, int n);
        longint acc;
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += clamp_result(longint'(a_elem[i*MAX_DIM + k]) * longint'(b_elem[k*MAX_DIM + j]));
        return clamp_result(acc);
    endfunction

    // Queue every product of a compute word in row-major order.
    function automatic void expect_products();
        int m;
        int n;
        int p;
        product_t item;
        m = effective_dim(rows_a);
        n = effective_dim(inner_len);
        p = effective_dim(cols_b);
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < p; j++) begin
                item.row   = POS_W'(i);
                item.col   = POS_W'(j);
                item.value = RES_W'(dot_product(i, j, n));
                item.last  = (i == m - 1) && (j == p - 1);
                expected_products.push_back(item);
            end
        end
    endfunction

    // Apply one accepted input word to the shadow state.
    function automatic void take_input_word();
        action_t act;
        int row;
        int col;
        logic signed [VALUE_W-1:0] value;
        act   = action_t'(s_axis_tuser);
        row   = int'(s_axis_tdata[POS_W-1:0]);
        col   = int'(s_axis_tdata[2*POS_W-1:POS_W]);
        value = s_axis_tdata[2*POS_W+VALUE_W-1:2*POS_W];
        case (act)
            ACT_WRITE_A:
                if (row < MAX_DIM && col < MAX_DIM)
                    a_elem[row*MAX_DIM + col] = value;
            ACT_WRITE_B:
                if (row < MAX_DIM && col < MAX_DIM)
                    b_elem[row*MAX_DIM + col] = value;
            ACT_COMPUTE:
                expect_products();
            default:
                ;
        endcase
    endfunction

    // Compare one accepted result word with the oldest expected product.
    function automatic void check_product_word();
        product_t got;
        product_t want;
        got.row   = m_axis_tdata[POS_W-1:0];
        got.col   = m_axis_tdata[2*POS_W-1:POS_W];
        got.value = m_axis_tdata[2*POS_W+RES_W-1:2*POS_W];
        got.last  = m_axis_tlast;
        if (expected_products.size() == 0) begin
            $error("unexpected result word: row %0d col %0d value %0d",
                   got.row, got.col, got.value);
            errors++;
            return;
        end
        want = expected_products.pop_front();
        if (got.row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, got.row);
            errors++;
        end
        if (got.col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, got.col);
            errors++;
        end
        if (got.value !== want.value) begin
            $error("product_value: expected %0d, got %0d", want.value, got.value);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
        end
    endfunction

    // Sample every channel at the clock edge; results are checked before a new
    // compute word appends its products.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rows_a    = DIM_RESET;
            inner_len = DIM_RESET;
            cols_b    = DIM_RESET;
            expected_products.delete();
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROWS_A:    rows_a    = cfg_data;
                    REG_INNER_LEN: inner_len = cfg_data;
                    REG_COLS_B:    cols_b    = cfg_data;
                    default:       ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_product_word();
            if (s_axis_tvalid && s_axis_tready)
                take_input_word();
            pending <= expected_products.size();
        end
    end

endmodule

/* sim/tb_dense_matrix_multiply_unit.sv */
// Testbench top for the dense matrix multiply unit: drives operand loads, compute
// words and dimension settings with random gaps and backpressure, and reports the verdict.
// Depends on dmm_pkg, dense_matrix_multiply_unit and dmm_result_checker.
module tb_dense_matrix_multiply_unit;
    import dmm_pkg::*;

    localparam int MAX_DIM       = 8;
    localparam int LOAD_TARGET   = 320;
    localparam int SETTLE_CYCLES = 20;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;  // row_index[2:0], col_index[5:3],
                                                 // elem_value[21:6], zero[23:22]
    logic [1:0]             s_axis_tuser  = '0;  // action[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;        // out_row[2:0], out_col[5:3],
                                                 // product_value[45:6], zero[47:46]
    logic                   m_axis_tlast;        // last

    int mismatch_count;
    int results_outstanding;

    // Which store entries hold a value, so a compute never reads an unwritten one.
    bit a_loaded [MAX_DIM*MAX_DIM];
    bit b_loaded [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0] dim_rows  = DIM_RESET;
    logic [CFG_W-1:0] dim_inner = DIM_RESET;
    logic [CFG_W-1:0] dim_cols  = DIM_RESET;
    bit steady_input = 1'b0;
    int words_sent = 0;

    dense_matrix_multiply_unit #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (VALUE_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    dmm_result_checker #(
        .MAX_DIM (MAX_DIM)
    ) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tlast        (m_axis_tlast),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    always #5 clk = ~clk;

    // The run is cut off here if results stop coming.
    initial
    begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result backpressure: short ready bursts and stalls, a few long stalls,
    // and now and then a long stretch with no stall at all.
    initial
    begin : ready_driver
        int len;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (len) @(posedge clk);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
            m_axis_tready <= 1'b0;
            repeat (len) @(posedge clk);
        end
    end

    function automatic int effective_dim(logic [CFG_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // Element values lean on the Q1.15 extremes.
    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Idle cycles before an input word: mostly none or short, a few long; none in steady mode.
    function automatic int input_gap();
        int r;
        if (steady_input)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one input word and hold it until the block takes it.
    task automatic send_word(action_t act, int row, int col, logic [VALUE_W-1:0] value);
        int gap;
        gap = input_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= IN_DATA_W'({value, POS_W'(col), POS_W'(row)});
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (act == ACT_WRITE_A)
            a_loaded[row*MAX_DIM + col] = 1'b1;
        if (act == ACT_WRITE_B)
            b_loaded[row*MAX_DIM + col] = 1'b1;
        if (act != ACT_NONE)
            words_sent++;
    endtask

    // Wait until every expected product has arrived and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program all three dimensions while the block is idle.
    task automatic set_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] inner,
                            logic [CFG_W-1:0] cols);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROWS_A;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= REG_INNER_LEN;
        cfg_data  <= inner;
        @(posedge clk);
        cfg_index <= REG_COLS_B;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dim_rows  = rows;
        dim_inner = inner;
        dim_cols  = cols;
    endtask

    // Load any operand entry the product will read but that was never written,
    // then issue the compute word with random contents in its ignored fields.
    task automatic compute_product();
        int m;
        int n;
        int p;
        m = effective_dim(dim_rows);
        n = effective_dim(dim_inner);
        p = effective_dim(dim_cols);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++)
                if (!a_loaded[i*MAX_DIM + k])
                    send_word(ACT_WRITE_A, i, k, random_value());
        for (int k = 0; k < n; k++)
            for (int j = 0; j < p; j++)
                if (!b_loaded[k*MAX_DIM + j])
                    send_word(ACT_WRITE_B, k, j, random_value());
        send_word(ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), VALUE_W'($urandom));
    endtask

    // Dimension choice for the random part: mostly small, with zero, oversize and full.
    function automatic logic [CFG_W-1:0] random_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return CFG_W'($urandom_range(9, 15));
        if (r <= 3)
            return CFG_W'(MAX_DIM);
        return CFG_W'($urandom_range(1, 4));
    endfunction

    // Main stimulus.
    initial
    begin : stimulus
        int m;
        int n;
        int p;
        int loads;
        int r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-element products at the sign extremes, plus an unused action.
        set_dims(4'd1, 4'd1, 4'd1);
        send_word(ACT_WRITE_A, 0, 0, 16'h8000);
        send_word(ACT_WRITE_B, 0, 0, 16'h8000);
        compute_product();
        send_word(ACT_WRITE_A, 0, 0, 16'h7FFF);
        compute_product();
        send_word(ACT_NONE, 7, 7, 16'hFFFF);
        send_word(ACT_WRITE_B, 0, 0, 16'h7FFF);
        compute_product();

        // Zero dimensions behave as one.
        set_dims(4'd0, 4'd0, 4'd0);
        compute_product();

        // A two-term sum of the largest products, and writes at the far corner.
        set_dims(4'd2, 4'd2, 4'd1);
        send_word(ACT_WRITE_A, 0, 0, 16'h8000);
        send_word(ACT_WRITE_A, 0, 1, 16'h8000);
        send_word(ACT_WRITE_A, 1, 0, 16'h8000);
        send_word(ACT_WRITE_A, 1, 1, 16'h7FFF);
        send_word(ACT_WRITE_B, 0, 0, 16'h8000);
        send_word(ACT_WRITE_B, 1, 0, 16'h8000);
        compute_product();
        send_word(ACT_WRITE_A, 7, 7, 16'h7FFF);
        send_word(ACT_WRITE_B, 7, 7, 16'h0001);

        // Random runs: mostly operand loads followed by a compute, with some
        // unused actions and writes outside the active region mixed in.
        while (words_sent < LOAD_TARGET)
        begin
            steady_input = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) != 0)
                set_dims(random_dim(), random_dim(), random_dim());
            m = effective_dim(dim_rows);
            n = effective_dim(dim_inner);
            p = effective_dim(dim_cols);
            loads = $urandom_range(1, m*n + n*p);
            repeat (loads)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    send_word(ACT_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                              random_value());
                else if (r == 1)
                    send_word($urandom_range(0, 1) ? ACT_WRITE_B : ACT_WRITE_A,
                              $urandom_range(0, 7), $urandom_range(0, 7), random_value());
                else if (r < 6)
                    send_word(ACT_WRITE_A, $urandom_range(0, m - 1), $urandom_range(0, n - 1),
                              random_value());
                else
                    send_word(ACT_WRITE_B, $urandom_range(0, n - 1), $urandom_range(0, p - 1),
                              random_value());
            end
            compute_product();
            // Sometimes change one element and recompute back to back.
            if ($urandom_range(0, 3) == 0)
            begin
                send_word(ACT_WRITE_B, $urandom_range(0, n - 1), $urandom_range(0, p - 1),
                          random_value());
                compute_product();
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/dmm_pkg.sv
design/dmm_ram.sv
design/dmm_ctrl.sv
design/dmm_datapath.sv
design/dense_matrix_multiply_unit.sv
sim/dmm_result_checker.sv
sim/tb_dense_matrix_multiply_unit.sv
